### src/fxa_pkg.sv
// ----------------------------------------------------------------------------
// fxa_pkg: shared types for the Q24.8 fixed-point ALU
// Operation codes, status codes and the item record that moves down the
// divider cell chain.
// ----------------------------------------------------------------------------
package fxa_pkg;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_GT       = 4'd4,
    OP_LT       = 4'd5,
    OP_GE       = 4'd6,
    OP_LE       = 4'd7,
    OP_EQ       = 4'd8,
    OP_NE       = 4'd9,
    OP_INC      = 4'd10,
    OP_DEC      = 4'd11,
    OP_MIN      = 4'd12,
    OP_MAX      = 4'd13,
    OP_TO_INT   = 4'd14,
    OP_FROM_INT = 4'd15
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_DIVZ = 2'd2
  } status_t;

  localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;

  // per-item record carried through the chain; dividend/quotient word rides
  // beside it since its width follows the fraction bits
  typedef struct packed {
    logic        valid;
    op_t         cmd;
    logic        neg;     // result sign for mul and div
    logic        dz;      // divisor is zero
    logic [31:0] res;     // finished result of the ops other than mul and div
    status_t     st;
    logic        cmp;
    logic [63:0] prod;    // magnitude product for mul
    logic [31:0] dvs;     // divisor magnitude
    logic [31:0] rem;     // partial remainder
  } item_t;

endpackage

### src/fxa_ifc.sv
// ----------------------------------------------------------------------------
// fxa_in_if / fxa_out_if: valid/ready channels of the fixed-point ALU
// A transfer happens at a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface fxa_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         cmd;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;

  modport source (output valid, output cmd, output operand_a, output operand_b,
                  input ready);
  modport sink   (input valid, input cmd, input operand_a, input operand_b,
                  output ready);
endinterface

interface fxa_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic               compare_true;
  logic [1:0]         status;

  modport source (output valid, output result_value, output compare_true,
                  output status, input ready);
  modport sink   (input valid, input result_value, input compare_true,
                  input status, output ready);
endinterface

### src/fixed_point_alu_q24_8.sv
// ----------------------------------------------------------------------------
// fixed_point_alu_q24_8: signed Q24.8 fixed-point ALU
//
//   channel  dir  fields                          transfer
//   in_ch    in   cmd, operand_a, operand_b       valid && ready
//   out_ch   out  result_value, compare_true,     valid && ready
//                 status
//
// One item per cycle while the output is not held; the division chain has
// FRACTION_BITS + 33 cells, one quotient bit per cell, between the entry
// and output registers. Every item takes the same path.
// Synchronous active-low reset empties the chain. When the output is held
// and not taken the whole chain holds and in_ch.ready drops.
// ----------------------------------------------------------------------------
module fixed_point_alu_q24_8 #(
  parameter int FRACTION_BITS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  fxa_in_if.sink    in_ch,
  fxa_out_if.source out_ch
);

  localparam int DW = 33 + FRACTION_BITS;

  logic               adv;
  logic [31:0]        a, b;
  logic [31:0]        mag_a, mag_b;
  logic [32:0]        sum, dif;
  logic [63:0]        fi_wide;
  logic               lt, eq;
  fxa_pkg::item_t     ent_nxt, ent_r;
  logic [DW-1:0]      dq_nxt, dq_r;
  fxa_pkg::item_t     chain_item [DW+1];
  logic [DW-1:0]      chain_dq   [DW+1];
  logic [31:0]        out_res;
  logic [1:0]         out_st;

  // whole chain moves unless the output register is held
  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  // results of the ops other than mul and div, mul product and division setup
  always_comb begin
    a       = in_ch.operand_a;
    b       = in_ch.operand_b;
    mag_a   = a[31] ? (32'd0 - a) : a;
    mag_b   = b[31] ? (32'd0 - b) : b;
    sum     = {a[31], a} + {b[31], b};
    dif     = {a[31], a} - {b[31], b};
    fi_wide = {{32{a[31]}}, a} << FRACTION_BITS;
    lt      = ($signed(a) < $signed(b));
    eq      = (a == b);

    ent_nxt.valid = in_ch.valid;
    ent_nxt.cmd   = fxa_pkg::op_t'(in_ch.cmd);
    ent_nxt.neg   = a[31] ^ b[31];
    ent_nxt.dz    = (b == 32'd0);
    ent_nxt.res   = 32'd0;
    ent_nxt.st    = fxa_pkg::ST_OK;
    ent_nxt.cmp   = 1'b0;
    ent_nxt.prod  = mag_a * mag_b;
    ent_nxt.dvs   = mag_b;
    ent_nxt.rem   = 32'd0;
    dq_nxt        = {mag_a, {(FRACTION_BITS + 1){1'b0}}};

    unique case (ent_nxt.cmd)
      fxa_pkg::OP_ADD: begin
        if (sum[32] != sum[31]) begin
          ent_nxt.res = sum[32] ? fxa_pkg::S32_MIN : fxa_pkg::S32_MAX;
          ent_nxt.st  = fxa_pkg::ST_OVF;
        end else begin
          ent_nxt.res = sum[31:0];
        end
      end
      fxa_pkg::OP_SUB: begin
        if (dif[32] != dif[31]) begin
          ent_nxt.res = dif[32] ? fxa_pkg::S32_MIN : fxa_pkg::S32_MAX;
          ent_nxt.st  = fxa_pkg::ST_OVF;
        end else begin
          ent_nxt.res = dif[31:0];
        end
      end
      fxa_pkg::OP_MUL, fxa_pkg::OP_DIV: ent_nxt.res = 32'd0;
      fxa_pkg::OP_GT: ent_nxt.cmp = !lt && !eq;
      fxa_pkg::OP_LT: ent_nxt.cmp = lt;
      fxa_pkg::OP_GE: ent_nxt.cmp = !lt;
      fxa_pkg::OP_LE: ent_nxt.cmp = lt || eq;
      fxa_pkg::OP_EQ: ent_nxt.cmp = eq;
      fxa_pkg::OP_NE: ent_nxt.cmp = !eq;
      fxa_pkg::OP_INC: ent_nxt.res = a + 32'd1;
      fxa_pkg::OP_DEC: ent_nxt.res = a - 32'd1;
      fxa_pkg::OP_MIN: ent_nxt.res = lt ? a : b;
      fxa_pkg::OP_MAX: ent_nxt.res = (!lt && !eq) ? a : b;
      fxa_pkg::OP_TO_INT: ent_nxt.res = 32'($signed(a) >>> FRACTION_BITS);
      fxa_pkg::OP_FROM_INT: begin
        if ($signed(fi_wide) > $signed(64'h0000_0000_7FFF_FFFF)) begin
          ent_nxt.res = fxa_pkg::S32_MAX;
          ent_nxt.st  = fxa_pkg::ST_OVF;
        end else if ($signed(fi_wide) < $signed(64'hFFFF_FFFF_8000_0000)) begin
          ent_nxt.res = fxa_pkg::S32_MIN;
          ent_nxt.st  = fxa_pkg::ST_OVF;
        end else begin
          ent_nxt.res = fi_wide[31:0];
        end
      end
      default: ent_nxt.res = 32'd0;
    endcase
  end

  // entry register: control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
    end else if (adv) begin
      ent_r.valid <= ent_nxt.valid;
    end
  end

  // entry register: payload
  always_ff @(posedge clk) begin
    if (adv) begin
      ent_r.cmd  <= ent_nxt.cmd;
      ent_r.neg  <= ent_nxt.neg;
      ent_r.dz   <= ent_nxt.dz;
      ent_r.res  <= ent_nxt.res;
      ent_r.st   <= ent_nxt.st;
      ent_r.cmp  <= ent_nxt.cmp;
      ent_r.prod <= ent_nxt.prod;
      ent_r.dvs  <= ent_nxt.dvs;
      ent_r.rem  <= ent_nxt.rem;
      dq_r       <= dq_nxt;
    end
  end

  assign chain_item[0] = ent_r;
  assign chain_dq[0]   = dq_r;

  // division cell chain, one quotient bit per cell
  for (genvar i = 0; i < DW; i++) begin : g_cell
    fxa_cell #(.DW(DW)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .item_in  (chain_item[i]),
      .dq_in    (chain_dq[i]),
      .item_out (chain_item[i+1]),
      .dq_out   (chain_dq[i+1])
    );
  end

  fxa_back #(.FB(FRACTION_BITS), .DW(DW)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .item_in   (chain_item[DW]),
    .quo_in    (chain_dq[DW]),
    .out_valid (out_ch.valid),
    .out_res   (out_res),
    .out_cmp   (out_ch.compare_true),
    .out_st    (out_st)
  );

  assign out_ch.result_value = out_res;
  assign out_ch.status       = out_st;

  // divide by zero always gives a zero result
  a_divz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_st == fxa_pkg::ST_DIVZ) |-> (out_res == 32'd0))
    else $error("divide by zero result not zero");

  // a comparison outcome never comes with a bad status
  a_cmp_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.compare_true) |-> (out_st == fxa_pkg::ST_OK))
    else $error("compare flag with non-ok status");

  // an accepted item lands in the entry register
  a_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> ent_r.valid)
    else $error("accepted item lost at entry");

  // a held output keeps the chain frozen
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> $stable(ent_r.valid))
    else $error("chain moved while output held");

endmodule

### src/fxa_cell.sv
// ----------------------------------------------------------------------------
// fxa_cell: one restoring-division cell
// Brings one dividend bit into the remainder, produces one quotient bit and
// registers the item for the next cell.
// ----------------------------------------------------------------------------
module fxa_cell #(
  parameter int DW = 41
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  fxa_pkg::item_t        item_in,
  input  logic [DW-1:0]         dq_in,
  output fxa_pkg::item_t        item_out,
  output logic [DW-1:0]         dq_out
);

  fxa_pkg::item_t item_r, item_nxt;
  logic [DW-1:0]  dq_r, dq_nxt;
  logic [32:0]    rem_sh;
  logic [32:0]    rem_sub;
  logic           qbit;

  // shift one dividend bit in and try the subtract
  always_comb begin
    rem_sh   = {item_in.rem, dq_in[DW-1]};
    rem_sub  = rem_sh - {1'b0, item_in.dvs};
    qbit     = (rem_sh >= {1'b0, item_in.dvs});
    item_nxt = item_in;
    item_nxt.rem = qbit ? rem_sub[31:0] : rem_sh[31:0];
    dq_nxt   = {dq_in[DW-2:0], qbit};
  end

  // control bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.valid <= 1'b0;
    end else if (adv) begin
      item_r.valid <= item_nxt.valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv) begin
      item_r.cmd  <= item_nxt.cmd;
      item_r.neg  <= item_nxt.neg;
      item_r.dz   <= item_nxt.dz;
      item_r.res  <= item_nxt.res;
      item_r.st   <= item_nxt.st;
      item_r.cmp  <= item_nxt.cmp;
      item_r.prod <= item_nxt.prod;
      item_r.dvs  <= item_nxt.dvs;
      item_r.rem  <= item_nxt.rem;
      dq_r        <= dq_nxt;
    end
  end

  assign item_out = item_r;
  assign dq_out   = dq_r;

endmodule

### src/fxa_back.sv
// ----------------------------------------------------------------------------
// fxa_back: rounding, saturation and output register
// Finishes mul and div, picks the result and holds it for the sink.
// ----------------------------------------------------------------------------
module fxa_back #(
  parameter int FB = 8,
  parameter int DW = 41
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  fxa_pkg::item_t  item_in,
  input  logic [DW-1:0]   quo_in,
  output logic            out_valid,
  output logic [31:0]     out_res,
  output logic            out_cmp,
  output logic [1:0]      out_st
);

  logic [63:0]      mul_q;
  logic [DW:0]      div_q;
  logic [63:0]      mag;
  logic [63:0]      lim;
  logic [31:0]      sat_res;
  logic             sat_ovf;
  logic             valid_r;
  logic [31:0]      res_r, res_nxt;
  logic             cmp_r, cmp_nxt;
  logic [1:0]       st_r, st_nxt;

  // round half away from zero on magnitudes
  always_comb begin
    mul_q = (item_in.prod + (64'd1 << (FB - 1))) >> FB;
    div_q = ({1'b0, quo_in} + {{DW{1'b0}}, 1'b1}) >> 1;
    mag   = (item_in.cmd == fxa_pkg::OP_MUL) ? mul_q : 64'(div_q);
    lim   = item_in.neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    sat_ovf = (mag > lim);
    if (sat_ovf) begin
      sat_res = item_in.neg ? fxa_pkg::S32_MIN : fxa_pkg::S32_MAX;
    end else begin
      sat_res = item_in.neg ? (32'd0 - mag[31:0]) : mag[31:0];
    end
  end

  // result select
  always_comb begin
    res_nxt = item_in.res;
    cmp_nxt = item_in.cmp;
    st_nxt  = item_in.st;
    if (item_in.cmd == fxa_pkg::OP_MUL) begin
      res_nxt = sat_res;
      st_nxt  = sat_ovf ? fxa_pkg::ST_OVF : fxa_pkg::ST_OK;
    end else if (item_in.cmd == fxa_pkg::OP_DIV) begin
      if (item_in.dz) begin
        res_nxt = 32'd0;
        st_nxt  = fxa_pkg::ST_DIVZ;
      end else begin
        res_nxt = sat_res;
        st_nxt  = sat_ovf ? fxa_pkg::ST_OVF : fxa_pkg::ST_OK;
      end
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= item_in.valid;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
      cmp_r <= cmp_nxt;
      st_r  <= st_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;
  assign out_cmp   = cmp_r;
  assign out_st    = st_r;

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the Q24.8 fixed-point ALU
// Directed items for every operation and its corner values, then random
// items with random sender bursts and receiver stalls. Each result is
// checked field by field against an in-line prediction of the ALU.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int FRAC    = 8;
  localparam int LATENCY = FRAC + 35;
  localparam int WD_MAX  = 20000;

  typedef struct {
    logic [31:0]      value;
    logic             cmp;
    fxa_pkg::status_t st;
  } alu_result_t;

  logic clk;
  logic rst_n;

  fxa_in_if  in_ch ();
  fxa_out_if out_ch ();

  fixed_point_alu_q24_8 #(.FRACTION_BITS(FRAC)) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  alu_result_t pending_results[$];
  int          mismatch_cnt = 0;
  int          idle_cycles = 0;
  bit          rx_hold;    // long receiver hold-off request
  bit          tx_burst;   // sender works in bursts when set

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // saturate a 64-bit signed value to 32 bits
  function automatic logic [31:0] sat32(input logic signed [63:0] v,
                                        inout fxa_pkg::status_t st);
    if (v > 64'sd2147483647) begin
      st = fxa_pkg::ST_OVF;
      return fxa_pkg::S32_MAX;
    end
    if (v < -64'sd2147483648) begin
      st = fxa_pkg::ST_OVF;
      return fxa_pkg::S32_MIN;
    end
    return v[31:0];
  endfunction

  // expected ALU output for one operation
  function automatic alu_result_t alu_predict(input fxa_pkg::op_t op,
                                             input logic signed [31:0] a,
                                             input logic signed [31:0] b);
    alu_result_t       r;
    logic signed [63:0] a64, b64;
    logic [63:0]       ma, mb, q, n;
    logic              neg;
    r.value = '0;
    r.cmp   = 1'b0;
    r.st    = fxa_pkg::ST_OK;
    a64 = a;
    b64 = b;
    ma  = (a64 < 0) ? -a64 : a64;
    mb  = (b64 < 0) ? -b64 : b64;
    neg = (a < 0) != (b < 0);
    case (op)
      fxa_pkg::OP_ADD: r.value = sat32(a64 + b64, r.st);
      fxa_pkg::OP_SUB: r.value = sat32(a64 - b64, r.st);
      fxa_pkg::OP_MUL: begin
        q = (ma * mb + (64'd1 << (FRAC - 1))) >> FRAC;
        r.value = sat32(neg ? -$signed(q) : $signed(q), r.st);
      end
      fxa_pkg::OP_DIV: begin
        if (b == 0) begin
          r.st = fxa_pkg::ST_DIVZ;
        end else begin
          n = ma << FRAC;
          q = (2 * n + mb) / (2 * mb);
          r.value = sat32(neg ? -$signed(q) : $signed(q), r.st);
        end
      end
      fxa_pkg::OP_GT: r.cmp = a > b;
      fxa_pkg::OP_LT: r.cmp = a < b;
      fxa_pkg::OP_GE: r.cmp = a >= b;
      fxa_pkg::OP_LE: r.cmp = a <= b;
      fxa_pkg::OP_EQ: r.cmp = a == b;
      fxa_pkg::OP_NE: r.cmp = a != b;
      fxa_pkg::OP_INC: r.value = a + 32'd1;
      fxa_pkg::OP_DEC: r.value = a - 32'd1;
      fxa_pkg::OP_MIN: r.value = (a < b) ? a : b;
      fxa_pkg::OP_MAX: r.value = (a > b) ? a : b;
      fxa_pkg::OP_TO_INT: r.value = a >>> FRAC;
      default: r.value = sat32(a64 <<< FRAC, r.st);
    endcase
    return r;
  endfunction

  // send one item and record what it should produce
  task automatic send_item(input fxa_pkg::op_t op, input logic [31:0] a,
                           input logic [31:0] b);
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= op;
    in_ch.operand_a <= a;
    in_ch.operand_b <= b;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(alu_predict(op, a, b));
  endtask

  // drop valid for a gap of the given length, if it is nonzero
  task automatic tx_gap(input int cycles);
    if (cycles > 0) begin
      in_ch.valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // random operand with bias toward corner values
  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return fxa_pkg::S32_MAX - $urandom_range(0, 3);
      1: return fxa_pkg::S32_MIN + $urandom_range(0, 3);
      2: return $urandom_range(0, 512) - 256;
      3: return $urandom_range(0, 1) ? 32'h0000_B504 + $urandom_range(0, 64) :
                                       -(32'h0000_B504 + $urandom_range(0, 64));
      default: return $urandom;
    endcase
  endfunction

  // corner values of each operation
  task automatic test_directed();
    send_item(fxa_pkg::OP_ADD, fxa_pkg::S32_MAX, 32'd1);
    send_item(fxa_pkg::OP_ADD, fxa_pkg::S32_MIN, 32'hFFFF_FFFF);
    send_item(fxa_pkg::OP_SUB, fxa_pkg::S32_MIN, 32'd1);
    send_item(fxa_pkg::OP_SUB, 32'd5, fxa_pkg::S32_MIN);
    send_item(fxa_pkg::OP_MUL, fxa_pkg::S32_MAX, fxa_pkg::S32_MAX);
    send_item(fxa_pkg::OP_MUL, 32'h0000_0180, 32'hFFFF_FF80);
    send_item(fxa_pkg::OP_MUL, fxa_pkg::S32_MIN, fxa_pkg::S32_MIN);
    send_item(fxa_pkg::OP_DIV, 32'd100, 32'd0);
    send_item(fxa_pkg::OP_DIV, fxa_pkg::S32_MIN, 32'hFFFF_FFFF);
    send_item(fxa_pkg::OP_DIV, 32'd1, 32'd3);
    send_item(fxa_pkg::OP_DIV, 32'hFFFF_FF80, 32'd512);
    send_item(fxa_pkg::OP_GT, fxa_pkg::S32_MAX, fxa_pkg::S32_MIN);
    send_item(fxa_pkg::OP_LT, fxa_pkg::S32_MIN, fxa_pkg::S32_MAX);
    send_item(fxa_pkg::OP_GE, 32'd7, 32'd7);
    send_item(fxa_pkg::OP_LE, 32'd7, 32'd6);
    send_item(fxa_pkg::OP_EQ, fxa_pkg::S32_MIN, fxa_pkg::S32_MIN);
    send_item(fxa_pkg::OP_NE, 32'd0, 32'd0);
    send_item(fxa_pkg::OP_INC, fxa_pkg::S32_MAX, 32'hFFFF_FFFF);
    send_item(fxa_pkg::OP_DEC, fxa_pkg::S32_MIN, 32'd0);
    send_item(fxa_pkg::OP_MIN, 32'd9, 32'd9);
    send_item(fxa_pkg::OP_MAX, fxa_pkg::S32_MIN, 32'hFFFF_FFFF);
    send_item(fxa_pkg::OP_TO_INT, 32'hFFFF_FF01, 32'd0);
    send_item(fxa_pkg::OP_TO_INT, fxa_pkg::S32_MAX, 32'd0);
    send_item(fxa_pkg::OP_FROM_INT, 32'h0080_0000, 32'd0);
    send_item(fxa_pkg::OP_FROM_INT, 32'hFF7F_FFFF, 32'd0);
    tx_gap(0);
  endtask

  // random items in bursts, with random gaps when tx_burst is set
  task automatic test_random(input int count);
    int burst;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 30);
        tx_gap(tx_burst ? $urandom_range(0, 6) : 0);
      end
      send_item(fxa_pkg::op_t'($urandom_range(0, 15)), rand_operand(), rand_operand());
      burst--;
    end
    in_ch.valid <= 1'b0;
  endtask

  // receiver holds off long enough for the chain to fill and stall input
  task automatic test_backpressure();
    rx_hold = 1'b1;
    for (int i = 0; i < 80; i++)
      send_item(fxa_pkg::op_t'($urandom_range(0, 15)), rand_operand(), rand_operand());
    in_ch.valid <= 1'b0;
  endtask

  // sender pauses until the chain has drained, then sends random items
  task automatic test_drain_pause();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    test_random(40);
  endtask

  // receiver ready pattern; one long hold once requested
  initial begin
    int hold_cnt;
    hold_cnt = 0;
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (rx_hold && hold_cnt < 3 * LATENCY) begin
        out_ch.ready <= 1'b0;
        hold_cnt++;
      end else begin
        case ($urandom_range(0, 3))
          0: out_ch.ready <= ($urandom_range(0, 3) == 0);
          1: out_ch.ready <= 1'b1;
          default: out_ch.ready <= ($urandom_range(0, 1) == 1);
        endcase
      end
    end
  end

  // result check
  always @(posedge clk) begin
    alu_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result transfer: value %h", out_ch.result_value);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_ch.result_value !== exp_r.value || out_ch.compare_true !== exp_r.cmp ||
            out_ch.status !== exp_r.st) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: value exp %h got %h, cmp exp %b got %b, st exp %0d got %0d",
                     exp_r.value, out_ch.result_value, exp_r.cmp,
                     out_ch.compare_true, exp_r.st, out_ch.status);
        end
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_MAX) begin
      $display("FAILURE");
      $finish;
    end
  end

  // main sequence
  initial begin
    int settle;
    rx_hold         = 1'b0;
    tx_burst        = 1'b0;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.cmd       <= fxa_pkg::OP_ADD;
    in_ch.operand_a <= '0;
    in_ch.operand_b <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(150);
    tx_burst = 1'b1;
    test_random(150);
    test_backpressure();
    test_drain_pause();
    settle = 0;
    while (pending_results.size() != 0) @(posedge clk);
    while (settle < 2 * LATENCY) begin
      @(posedge clk);
      settle++;
    end
    if (mismatch_cnt == 0 && pending_results.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

### files.f
src/fxa_pkg.sv
src/fxa_ifc.sv
src/fxa_cell.sv
src/fxa_back.sv
src/fixed_point_alu_q24_8.sv
tb/tb_top.sv
